/* rtl/lru_cache_byte_and_entry_budget_macros.svh */
// Assertion macros for the LRU cache block checker.
`ifndef LRU_CACHE_BYTE_AND_ENTRY_BUDGET_MACROS_SVH
`define LRU_CACHE_BYTE_AND_ENTRY_BUDGET_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lcb_pkg.sv */
// Shared types and codes of the LRU cache block.
package lcb_pkg;

   localparam logic [2:0] OP_LOOKUP = 3'd0;
   localparam logic [2:0] OP_STORE  = 3'd1;
   localparam logic [2:0] OP_PURGE  = 3'd2;
   localparam logic [2:0] OP_PREFIX = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [3:0] ST_MISS      = 4'd0;
   localparam logic [3:0] ST_FRESH     = 4'd1;
   localparam logic [3:0] ST_STALE     = 4'd2;
   localparam logic [3:0] ST_STORED    = 4'd3;
   localparam logic [3:0] ST_REJECTED  = 4'd4;
   localparam logic [3:0] ST_PURGED    = 4'd5;
   localparam logic [3:0] ST_NOT_FOUND = 4'd6;
   localparam logic [3:0] ST_PFX_DONE  = 4'd7;
   localparam logic [3:0] ST_CLEARED   = 4'd8;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_BYTES   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ENTRIES = 2'd1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] key;
      logic [3:0]  prefix_len;
      logic [31:0] now;
      logic        entry_present;
      logic [31:0] entry_handle;
      logic [31:0] entry_bytes;
      logic [31:0] entry_expires;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] hit_handle;
      logic [6:0]  removed_count;
      logic [6:0]  entry_count;
      logic [31:0] total_bytes;
   } rsp_type;

   typedef struct packed {
      logic key_eq;
      logic pfx_eq;
      logic rank_lt;
      logic rank_gt;
      logic rank_old;
   } eval_type;

endpackage

/* rtl/lcb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lcb_eval.sv */
// Per-slot compare unit: key, prefix and age rank tests on one read word.
module lcb_eval #(
   parameter int KEY_BITS  = 64,
   parameter int RANK_BITS = 6
) (
   input  logic [KEY_BITS-1:0]  slot_key,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic [3:0]           prefix_len,
   input  logic [RANK_BITS-1:0] slot_rank,
   input  logic [RANK_BITS-1:0] ref_rank,
   input  logic [RANK_BITS-1:0] old_rank,
   output lcb_pkg::eval_type    result
);

   logic [6:0]          nbits;
   logic [KEY_BITS-1:0] pmask;

   always_comb begin
      nbits = (prefix_len > 4'd8) ? 7'd64 : {prefix_len, 3'b000};
      for (int j = 0; j < KEY_BITS; j++) begin
         pmask[j] = (nbits != 7'd0) && ((32'(j) + 32'(nbits)) >= 32'(KEY_BITS));
      end
   end

   assign result.key_eq   = (slot_key == req_key);
   assign result.pfx_eq   = (((slot_key ^ req_key) & pmask) == '0);
   assign result.rank_lt  = (slot_rank < ref_rank);
   assign result.rank_gt  = (slot_rank > ref_rank);
   assign result.rank_old = (slot_rank == old_rank);

endmodule

/* rtl/lru_cache_byte_and_entry_budget.sv */
// Top level of the LRU cache table with byte and entry budgets.
//
//  channel  ports                         handshake
//  -------  ----------------------------  ------------------------------
//  request  start busy req_data           word taken when start && !busy
//  result   rsp_strobe rsp_data           one cycle, taken at its end
//  config   csr_valid csr_ready csr_*     write when csr_valid && csr_ready
//
// Each operation walks the slot RAM (one read port, one word a cycle), with control
// states between walks. Lookup: 1-2 walks; purge: 1-2; store: 2-3 plus one per
// eviction; prefix purge: 1 + 2 per removed entry; reject, clear, unknown opcode:
// none. DONE registers the result, and the strobe follows in the next cycle. Valid
// bits are flip-flops cleared by reset at once; no clearing pass. Results cannot
// be stalled.
module lru_cache_byte_and_entry_budget #(
   parameter int CAPACITY    = 64,
   parameter int KEY_BITS    = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  lcb_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output lcb_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lcb_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [31:0]                        csr_data
);

   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int RANK_BITS = IDX_BITS;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int CMP_BITS  = (CNT_BITS > 7) ? CNT_BITS : 7;
   localparam int SIZE_LO   = RANK_BITS;
   localparam int EXP_LO    = SIZE_LO + 32;
   localparam int HND_LO    = EXP_LO + 32;
   localparam int KEY_LO    = HND_LO + HANDLE_BITS;
   localparam int WORD_BITS = KEY_LO + KEY_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_FIND_END, S_RECENT, S_INSERT, S_EVCHK,
      S_OLDEST, S_OLD_END, S_PFIND, S_PF_END, S_DEC, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   lcb_pkg::req_type      req_ff, req_in;
   logic [CNT_BITS-1:0]   pass_ff, pass_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [32:0]           held_bytes_ff, held_bytes_in;
   logic [CNT_BITS-1:0]   held_count_ff, held_count_in;
   logic [31:0]           max_bytes_ff, max_bytes_in;
   logic [6:0]            max_entries_ff, max_entries_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   found_idx_ff, found_idx_in;
   logic [RANK_BITS-1:0]  found_rank_ff, found_rank_in;
   logic [31:0]           found_size_ff, found_size_in;
   logic [31:0]           found_exp_ff, found_exp_in;
   logic [HANDLE_BITS-1:0] found_hnd_ff, found_hnd_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  refill_ff, refill_in;
   logic [3:0]            status_ff, status_in;
   logic [31:0]           hit_ff, hit_in;
   logic [6:0]            removed_ff, removed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lcb_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [WORD_BITS-1:0]   rd_data;
   logic [IDX_BITS-1:0]    d_idx;
   logic                   d_ok;
   logic                   last;
   logic                   d_valid;
   logic [RANK_BITS-1:0]   d_rank;
   logic [KEY_BITS-1:0]    d_key;
   logic [RANK_BITS-1:0]   old_rank;
   logic [KEY_BITS-1:0]    req_key;
   logic [HANDLE_BITS+31:0] in_hnd_wide;
   logic [HANDLE_BITS-1:0] new_hnd;
   logic [HANDLE_BITS+31:0] out_hnd_wide;
   logic [CMP_BITS-1:0]    limit;
   logic                   over;
   lcb_pkg::eval_type      ev;

   lcb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pass_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign d_ok     = (pass_ff != '0);
   assign d_idx    = IDX_BITS'(pass_ff - CNT_BITS'(1));
   assign last     = (pass_ff == CNT_BITS'(CAPACITY));
   assign d_valid  = d_ok && valid_ff[d_idx];
   assign d_rank   = rd_data[RANK_BITS-1:0];
   assign d_key    = rd_data[KEY_LO +: KEY_BITS];
   assign old_rank = RANK_BITS'(held_count_ff - CNT_BITS'(1));
   assign req_key  = req_ff.key[KEY_BITS-1:0];

   assign in_hnd_wide  = {HANDLE_BITS'(0), req_ff.entry_handle};
   assign new_hnd      = in_hnd_wide[HANDLE_BITS-1:0];
   assign out_hnd_wide = {32'd0, found_hnd_ff};

   assign limit = (CMP_BITS'(max_entries_ff) > CMP_BITS'(CAPACITY)) ?
                  CMP_BITS'(CAPACITY) : CMP_BITS'(max_entries_ff);
   assign over  = (held_count_ff != '0) &&
                  ((held_bytes_ff > {1'b0, max_bytes_ff}) ||
                   (CMP_BITS'(held_count_ff) > limit));

   lcb_eval #(
      .KEY_BITS  (KEY_BITS),
      .RANK_BITS (RANK_BITS)
   ) u_eval (
      .slot_key   (d_key),
      .req_key    (req_key),
      .prefix_len (req_ff.prefix_len),
      .slot_rank  (d_rank),
      .ref_rank   (found_rank_ff),
      .old_rank   (old_rank),
      .result     (ev)
   );

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      pass_in        = pass_ff;
      valid_in       = valid_ff;
      held_bytes_in  = held_bytes_ff;
      held_count_in  = held_count_ff;
      max_bytes_in   = max_bytes_ff;
      max_entries_in = max_entries_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_rank_in  = found_rank_ff;
      found_size_in  = found_size_ff;
      found_exp_in   = found_exp_ff;
      found_hnd_in   = found_hnd_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      refill_in      = refill_ff;
      status_in      = status_ff;
      hit_in         = hit_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = d_idx;
      wr_data        = {rd_data[WORD_BITS-1:RANK_BITS], d_rank};

      if (csr_valid) begin
         case (csr_index)
            lcb_pkg::CSR_MAX_BYTES:   max_bytes_in   = csr_data;
            lcb_pkg::CSR_MAX_ENTRIES: max_entries_in = csr_data[6:0];
            default: ;
         endcase
      end

      // walks restart from address 0 out of EVCHK, whatever state led there
      if ((state_ff != S_IDLE) && (state_ff != S_DONE) && (state_ff != S_EVCHK) && !last) begin
         pass_in = pass_ff + CNT_BITS'(1);
      end else begin
         pass_in = '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               hit_in     = 32'd0;
               removed_in = 7'd0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               refill_in  = 1'b0;
               case (req_data.opcode)
                  lcb_pkg::OP_LOOKUP, lcb_pkg::OP_PURGE: state_in = S_FIND;
                  lcb_pkg::OP_STORE: begin
                     if (!req_data.entry_present || (req_data.entry_bytes > max_bytes_ff)) begin
                        status_in = lcb_pkg::ST_REJECTED;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  lcb_pkg::OP_PREFIX: state_in = S_PFIND;
                  lcb_pkg::OP_CLEAR: begin
                     valid_in      = '0;
                     held_bytes_in = '0;
                     held_count_in = '0;
                     status_in     = lcb_pkg::ST_CLEARED;
                     state_in      = S_DONE;
                  end
                  default: begin
                     status_in = lcb_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (d_valid && ev.key_eq && !found_ff) begin
               found_in      = 1'b1;
               found_idx_in  = d_idx;
               found_rank_in = d_rank;
               found_size_in = rd_data[SIZE_LO +: 32];
               found_exp_in  = rd_data[EXP_LO +: 32];
               found_hnd_in  = rd_data[HND_LO +: HANDLE_BITS];
            end
            if (d_ok && !valid_ff[d_idx] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = d_idx;
            end
            if (last) begin
               state_in = S_FIND_END;
            end
         end
         S_FIND_END: begin
            case (req_ff.opcode)
               lcb_pkg::OP_LOOKUP: begin
                  if (found_ff) begin
                     status_in = (req_ff.now < found_exp_ff) ?
                                 lcb_pkg::ST_FRESH : lcb_pkg::ST_STALE;
                     hit_in    = out_hnd_wide[31:0];
                     state_in  = S_RECENT;
                  end else begin
                     status_in = lcb_pkg::ST_MISS;
                     state_in  = S_DONE;
                  end
               end
               lcb_pkg::OP_STORE: begin
                  if (found_ff) begin
                     held_bytes_in = held_bytes_ff - {1'b0, found_size_ff};
                     state_in      = S_RECENT;
                  end else if (held_count_ff >= CNT_BITS'(CAPACITY)) begin
                     refill_in = 1'b1;
                     found_in  = 1'b0;
                     state_in  = S_OLDEST;
                  end else begin
                     state_in = S_INSERT;
                  end
               end
               lcb_pkg::OP_PURGE: begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     held_bytes_in = held_bytes_ff - {1'b0, found_size_ff};
                     held_count_in = held_count_ff - CNT_BITS'(1);
                     status_in     = lcb_pkg::ST_PURGED;
                     state_in      = S_DEC;
                  end else begin
                     status_in = lcb_pkg::ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RECENT: begin
            if (d_valid) begin
               if (d_idx == found_idx_ff) begin
                  wr_en = 1'b1;
                  if (req_ff.opcode == lcb_pkg::OP_STORE) begin
                     wr_data = {d_key, new_hnd, req_ff.entry_expires,
                                req_ff.entry_bytes, RANK_BITS'(0)};
                  end else begin
                     wr_data = {rd_data[WORD_BITS-1:RANK_BITS], RANK_BITS'(0)};
                  end
               end else if (ev.rank_lt) begin
                  wr_en   = 1'b1;
                  wr_data = {rd_data[WORD_BITS-1:RANK_BITS], d_rank + RANK_BITS'(1)};
               end
            end
            if (last) begin
               if (req_ff.opcode == lcb_pkg::OP_STORE) begin
                  held_bytes_in = held_bytes_ff + {1'b0, req_ff.entry_bytes};
                  state_in      = S_EVCHK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            if (d_ok && (d_idx == free_idx_ff)) begin
               wr_en   = 1'b1;
               wr_data = {req_key, new_hnd, req_ff.entry_expires,
                          req_ff.entry_bytes, RANK_BITS'(0)};
            end else if (d_valid) begin
               wr_en   = 1'b1;
               wr_data = {rd_data[WORD_BITS-1:RANK_BITS], d_rank + RANK_BITS'(1)};
            end
            if (last) begin
               valid_in[free_idx_ff] = 1'b1;
               held_count_in = held_count_ff + CNT_BITS'(1);
               held_bytes_in = held_bytes_ff + {1'b0, req_ff.entry_bytes};
               state_in      = S_EVCHK;
            end
         end
         S_EVCHK: begin
            if (over) begin
               found_in = 1'b0;
               state_in = S_OLDEST;
            end else begin
               status_in = lcb_pkg::ST_STORED;
               state_in  = S_DONE;
            end
         end
         S_OLDEST: begin
            if (d_valid && ev.rank_old && !found_ff) begin
               found_in      = 1'b1;
               found_idx_in  = d_idx;
               found_size_in = rd_data[SIZE_LO +: 32];
            end
            if (last) begin
               state_in = S_OLD_END;
            end
         end
         S_OLD_END: begin
            valid_in[found_idx_ff] = 1'b0;
            held_bytes_in = held_bytes_ff - {1'b0, found_size_ff};
            held_count_in = held_count_ff - CNT_BITS'(1);
            if (refill_ff) begin
               refill_in   = 1'b0;
               free_idx_in = found_idx_ff;
               state_in    = S_INSERT;
            end else begin
               state_in = S_EVCHK;
            end
         end
         S_PFIND: begin
            if (d_valid && ev.pfx_eq && !found_ff) begin
               found_in      = 1'b1;
               found_idx_in  = d_idx;
               found_rank_in = d_rank;
               found_size_in = rd_data[SIZE_LO +: 32];
            end
            if (last) begin
               state_in = S_PF_END;
            end
         end
         S_PF_END: begin
            if (found_ff) begin
               valid_in[found_idx_ff] = 1'b0;
               held_bytes_in = held_bytes_ff - {1'b0, found_size_ff};
               held_count_in = held_count_ff - CNT_BITS'(1);
               removed_in    = removed_ff + 7'd1;
               state_in      = S_DEC;
            end else begin
               status_in = lcb_pkg::ST_PFX_DONE;
               state_in  = S_DONE;
            end
         end
         S_DEC: begin
            if (d_valid && ev.rank_gt) begin
               wr_en   = 1'b1;
               wr_data = {rd_data[WORD_BITS-1:RANK_BITS], d_rank - RANK_BITS'(1)};
            end
            if (last) begin
               if (req_ff.opcode == lcb_pkg::OP_PURGE) begin
                  state_in = S_DONE;
               end else begin
                  found_in = 1'b0;
                  state_in = S_PFIND;
               end
            end
         end
         S_DONE: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = status_ff;
            rsp_in.hit_handle    = hit_ff;
            rsp_in.removed_count = removed_ff;
            rsp_in.entry_count   = 7'(held_count_ff);
            rsp_in.total_bytes   = held_bytes_ff[31:0];
            state_in             = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         valid_ff       <= '0;
         held_bytes_ff  <= '0;
         held_count_ff  <= '0;
         max_bytes_ff   <= 32'd16777216;
         max_entries_ff <= 7'd64;
         pass_ff        <= '0;
         found_ff       <= 1'b0;
         free_ff        <= 1'b0;
         refill_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         held_bytes_ff  <= held_bytes_in;
         held_count_ff  <= held_count_in;
         max_bytes_ff   <= max_bytes_in;
         max_entries_ff <= max_entries_in;
         pass_ff        <= pass_in;
         found_ff       <= found_in;
         free_ff        <= free_in;
         refill_ff      <= refill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff        <= req_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      found_size_ff <= found_size_in;
      found_exp_ff  <= found_exp_in;
      found_hnd_ff  <= found_hnd_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      removed_ff    <= removed_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

endmodule

/* rtl/lcb_checker.sv */
// Port-level checker for the LRU cache block, bound to the top level.
`include "lru_cache_byte_and_entry_budget_macros.svh"

module lcb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input lcb_pkg::rsp_type rsp_data
);

   `LCB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word left block idle")
   `LCB_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe too long")
   `LCB_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result shown while busy")
   `LCB_ASSERT_SAME(a_hit_zero, clock, reset, rsp_strobe && rsp_data.status != lcb_pkg::ST_FRESH && rsp_data.status != lcb_pkg::ST_STALE, rsp_data.hit_handle == 32'd0, "handle on non-hit result")

endmodule

bind lru_cache_byte_and_entry_budget lcb_checker u_lcb_checker (.*);

/* tb/lru_cache_byte_and_entry_budget_tb.sv */
// Testbench of the LRU cache table: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

class lru_table_scoreboard;
   bit          valid[64];
   logic [63:0] skey[64];
   logic [31:0] shandle[64];
   logic [31:0] sexpiry[64];
   logic [31:0] ssize[64];
   int unsigned srank[64];
   logic [32:0] held_bytes;
   int unsigned held_count;
   logic [31:0] max_bytes;
   logic [6:0]  max_entries;
   lcb_pkg::rsp_type expected_rsp[$];
   int unsigned errors;

   function new();
      max_bytes = 32'd16777216;
      max_entries = 7'd64;
      held_bytes = '0;
      held_count = 0;
      errors = 0;
      foreach (valid[i]) valid[i] = 0;
   endfunction

   function void set_reg(logic [lcb_pkg::CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      if (idx == lcb_pkg::CSR_MAX_BYTES) max_bytes = val;
      else if (idx == lcb_pkg::CSR_MAX_ENTRIES) max_entries = val[6:0];
   endfunction

   function int find_slot(logic [63:0] k);
      for (int i = 0; i < 64; i++)
         if (valid[i] && skey[i] == k) return i;
      return -1;
   endfunction

   function void promote(int s);
      int unsigned r;
      r = srank[s];
      for (int i = 0; i < 64; i++)
         if (valid[i] && srank[i] < r) srank[i]++;
      srank[s] = 0;
   endfunction

   function void drop_slot(int s);
      int unsigned r;
      r = srank[s];
      valid[s] = 0;
      held_bytes = held_bytes - ssize[s];
      held_count--;
      for (int i = 0; i < 64; i++)
         if (valid[i] && srank[i] > r) srank[i]--;
   endfunction

   function void drop_oldest();
      for (int i = 0; i < 64; i++)
         if (valid[i] && srank[i] + 1 == held_count) begin
            drop_slot(i);
            return;
         end
   endfunction

   function void note_word(lcb_pkg::req_type r);
      lcb_pkg::rsp_type e;
      int s;
      int unsigned lim, nbits;
      logic [63:0] pmask;
      e = '0;
      e.status = lcb_pkg::ST_NOT_FOUND;
      lim = (max_entries > 64) ? 64 : max_entries;
      case (r.opcode)
         lcb_pkg::OP_LOOKUP: begin
            s = find_slot(r.key);
            if (s < 0) e.status = lcb_pkg::ST_MISS;
            else begin
               promote(s);
               e.status = (r.now < sexpiry[s]) ? lcb_pkg::ST_FRESH : lcb_pkg::ST_STALE;
               e.hit_handle = shandle[s];
            end
         end
         lcb_pkg::OP_STORE: begin
            if (!r.entry_present || r.entry_bytes > max_bytes) e.status = lcb_pkg::ST_REJECTED;
            else begin
               s = find_slot(r.key);
               if (s >= 0) begin
                  held_bytes = held_bytes - ssize[s];
                  promote(s);
               end else begin
                  if (held_count >= 64) drop_oldest();
                  s = 0;
                  while (s < 64 && valid[s]) s++;
                  if (s == 64) s = 0;
                  for (int i = 0; i < 64; i++)
                     if (valid[i]) srank[i]++;
                  valid[s] = 1;
                  skey[s] = r.key;
                  srank[s] = 0;
                  held_count++;
               end
               shandle[s] = r.entry_handle;
               sexpiry[s] = r.entry_expires;
               ssize[s] = r.entry_bytes;
               held_bytes = held_bytes + r.entry_bytes;
               while (held_count > 0 && (held_bytes > {1'b0, max_bytes} || held_count > lim))
                  drop_oldest();
               e.status = lcb_pkg::ST_STORED;
            end
         end
         lcb_pkg::OP_PURGE: begin
            s = find_slot(r.key);
            if (s >= 0) begin
               drop_slot(s);
               e.status = lcb_pkg::ST_PURGED;
            end
         end
         lcb_pkg::OP_PREFIX: begin
            nbits = ((r.prefix_len > 8) ? 8 : r.prefix_len) * 8;
            pmask = (nbits == 0) ? 64'd0 : ~64'd0 << (64 - nbits);
            for (int i = 0; i < 64; i++)
               if (valid[i] && ((skey[i] ^ r.key) & pmask) == 0) begin
                  drop_slot(i);
                  e.removed_count++;
               end
            e.status = lcb_pkg::ST_PFX_DONE;
         end
         lcb_pkg::OP_CLEAR: begin
            foreach (valid[i]) valid[i] = 0;
            held_bytes = '0;
            held_count = 0;
            e.status = lcb_pkg::ST_CLEARED;
         end
         default: ;
      endcase
      e.entry_count = held_count[6:0];
      e.total_bytes = held_bytes[31:0];
      expected_rsp.push_back(e);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_word(lcb_pkg::rsp_type g);
      lcb_pkg::rsp_type e;
      if (expected_rsp.size() == 0) begin
         report("unexpected word", 64'(g.status), 64'd0);
         return;
      end
      e = expected_rsp.pop_front();
      if (g.status !== e.status) report("status", 64'(g.status), 64'(e.status));
      if (g.hit_handle !== e.hit_handle)
         report("hit_handle", 64'(g.hit_handle), 64'(e.hit_handle));
      if (g.removed_count !== e.removed_count)
         report("removed_count", 64'(g.removed_count), 64'(e.removed_count));
      if (g.entry_count !== e.entry_count)
         report("entry_count", 64'(g.entry_count), 64'(e.entry_count));
      if (g.total_bytes !== e.total_bytes)
         report("total_bytes", 64'(g.total_bytes), 64'(e.total_bytes));
   endtask
endclass

module lru_cache_byte_and_entry_budget_tb;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   lcb_pkg::req_type req_data = '0;
   logic rsp_strobe;
   lcb_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [lcb_pkg::CSR_IDX_BITS-1:0] csr_index = lcb_pkg::CSR_MAX_BYTES;
   logic [31:0] csr_data = '0;

   lru_table_scoreboard sb = new();
   logic [63:0] key_pool[24];
   bit burst;

   lru_cache_byte_and_entry_budget uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #2s;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_data);
   end

   task send_word(lcb_pkg::req_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start <= 1;
      do @(posedge clock); while (busy);
      sb.note_word(r);
   endtask

   task drain();
      start <= 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_reg(logic [lcb_pkg::CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      drain();
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(idx, val);
   endtask

   function lcb_pkg::req_type make_op(logic [2:0] op, logic [63:0] k);
      lcb_pkg::req_type r;
      r = '0;
      r.opcode = op;
      r.key = k;
      r.prefix_len = 4'($urandom_range(0, 15));
      r.now = $urandom();
      r.entry_present = 1;
      r.entry_handle = $urandom();
      r.entry_bytes = $urandom_range(0, 600);
      r.entry_expires = $urandom();
      return r;
   endfunction

   function lcb_pkg::req_type rand_word();
      lcb_pkg::req_type r;
      int p;
      logic [63:0] k;
      p = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                       : key_pool[$urandom_range(0, 23)];
      if (p < 40) r = make_op(lcb_pkg::OP_STORE, k);
      else if (p < 72) r = make_op(lcb_pkg::OP_LOOKUP, k);
      else if (p < 84) r = make_op(lcb_pkg::OP_PURGE, k);
      else if (p < 93) r = make_op(lcb_pkg::OP_PREFIX, k);
      else if (p < 96) r = make_op(lcb_pkg::OP_CLEAR, k);
      else r = make_op(3'($urandom_range(5, 7)), k);
      if (r.opcode == lcb_pkg::OP_STORE) begin
         if ($urandom_range(0, 19) == 0) r.entry_present = 0;
         if ($urandom_range(0, 9) == 0) r.entry_bytes = $urandom();
      end
      return r;
   endfunction

   initial begin
      lcb_pkg::req_type r;
      int unsigned cfg_bytes[7];
      int unsigned cfg_entries[7];
      foreach (key_pool[i]) key_pool[i] = {6'd0, 2'($urandom_range(0, 3)), 24'($urandom()),
                                           $urandom()};
      cfg_bytes = '{32'hFFFF_FFFF, 2000, 0, 500, 1000, 32'd16777216, 300};
      cfg_entries = '{127, 8, 0, 1, 3, 64, 64};
      burst = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default budgets
      send_word(make_op(lcb_pkg::OP_LOOKUP, 64'd0));
      r = make_op(lcb_pkg::OP_STORE, 64'd0); r.entry_expires = 100; send_word(r);
      r = make_op(lcb_pkg::OP_LOOKUP, 64'd0); r.now = 50; send_word(r);
      r.now = 100; send_word(r);
      r = make_op(lcb_pkg::OP_STORE, 64'd0); r.entry_bytes = 0; send_word(r);
      r = make_op(lcb_pkg::OP_STORE, ~64'd0); r.entry_bytes = 32'd16777216; send_word(r);
      r = make_op(lcb_pkg::OP_STORE, 64'h1234); r.entry_bytes = 32'd16777217; send_word(r);
      r = make_op(lcb_pkg::OP_STORE, 64'h1234); r.entry_present = 0; send_word(r);
      r = make_op(lcb_pkg::OP_LOOKUP, ~64'd0); r.now = 0; send_word(r);
      r.now = '1; send_word(r);
      send_word(make_op(lcb_pkg::OP_PURGE, ~64'd0));
      send_word(make_op(lcb_pkg::OP_PURGE, ~64'd0));
      for (int i = 0; i < 6; i++) send_word(make_op(lcb_pkg::OP_STORE, {8'hA5, 8'(i), 48'd7}));
      r = make_op(lcb_pkg::OP_PREFIX, {8'hA5, 8'd2, 48'd0}); r.prefix_len = 2; send_word(r);
      r.prefix_len = 8; r.key = {8'hA5, 8'd3, 48'd7}; send_word(r);
      r.prefix_len = 12; r.key = {8'hA5, 8'd4, 48'd7}; send_word(r);
      r.prefix_len = 1; r.key = {8'hA5, 56'd0}; send_word(r);
      send_word(make_op(lcb_pkg::OP_STORE, 64'd9));
      r = make_op(lcb_pkg::OP_PREFIX, 64'd0); r.prefix_len = 0; send_word(r);
      send_word(make_op(lcb_pkg::OP_STORE, 64'd9));
      send_word(make_op(lcb_pkg::OP_CLEAR, 64'd0));
      for (int op = 5; op < 8; op++) send_word(make_op(3'(op), 64'd9));

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(lcb_pkg::CSR_MAX_BYTES, cfg_bytes[ph]);
         write_reg(lcb_pkg::CSR_MAX_ENTRIES, cfg_entries[ph]);
         for (int n = 0; n < 260; n++) begin
            if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
            if (n == 130) drain();
            send_word(rand_word());
         end
      end

      start <= 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

/* lru_cache_byte_and_entry_budget.f */
+incdir+rtl
rtl/lcb_pkg.sv
rtl/lcb_ram.sv
rtl/lcb_eval.sv
rtl/lru_cache_byte_and_entry_budget.sv
rtl/lcb_checker.sv
tb/lru_cache_byte_and_entry_budget_tb.sv
